@@ rtl/euler_flux_2d_unit_assert.svh @@
// ----------------------------------------------------------------------------
// euler_flux_2d_unit assertion macros
// Concurrent check wrappers shared by the flux unit.
// ----------------------------------------------------------------------------
`ifndef EULER_FLUX_2D_UNIT_ASSERT_SVH
`define EULER_FLUX_2D_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define EFLX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flux unit check failed");

// Next-cycle implication, disabled while reset is held.
`define EFLX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flux unit check failed");

`endif

@@ rtl/eflx_pkg.sv @@
// ----------------------------------------------------------------------------
// eflx_pkg
// Shared constants and types of the 2D Euler flux unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eflx_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ISQRT_STAGES  = 32;
    localparam int IN_TDATA_W    = 224;
    localparam int OUT_TDATA_W   = 128;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

endpackage

@@ rtl/eflx_isqrt.sv @@
// ----------------------------------------------------------------------------
// eflx_isqrt
// Pipelined floor square root of a 64 bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eflx_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);
    import eflx_pkg::*;

    logic [63:0] r_x    [ISQRT_STAGES];
    logic [35:0] r_rem  [ISQRT_STAGES];
    logic [31:0] r_root [ISQRT_STAGES];

    for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_step
        logic [63:0] x_i;
        logic [35:0] rem_i;
        logic [31:0] root_i;
        logic [35:0] acc;
        logic [35:0] trial;

        if (k == 0) begin : g_first
            assign x_i    = i_rad;
            assign rem_i  = '0;
            assign root_i = '0;
        end else begin : g_next
            assign x_i    = r_x[k-1];
            assign rem_i  = r_rem[k-1];
            assign root_i = r_root[k-1];
        end

        // bring down the next two radicand bits, try 4*root + 1
        assign acc   = {rem_i[33:0], x_i[63:62]};
        assign trial = {2'b00, root_i, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= {x_i[61:0], 2'b00};
                if (acc >= trial) begin
                    r_rem[k]  <= acc - trial;
                    r_root[k] <= {root_i[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= acc;
                    r_root[k] <= {root_i[30:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ISQRT_STAGES-1];

endmodule

@@ rtl/eflx_div.sv @@
// ----------------------------------------------------------------------------
// eflx_div
// Pipelined restoring divide of (num << FRAC_BITS) by den, one quotient bit
// per stage. Expects num <= den, so the quotient fits FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eflx_div #(
    parameter int FRAC_BITS = eflx_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_num,
    input  logic [31:0]          i_den,
    output logic [FRAC_BITS:0]   o_quo
);
    localparam int STAGES = FRAC_BITS + 1;

    logic [31:0]        r_rem [STAGES];
    logic [31:0]        r_den [STAGES];
    logic [FRAC_BITS:0] r_quo [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_step
        logic [31:0]        rem_i;
        logic [31:0]        den_i;
        logic [FRAC_BITS:0] quo_i;
        logic               bit_i;
        logic [32:0]        acc;

        if (k == 0) begin : g_first
            // upper dividend bits are num >> 1, already below den
            assign rem_i = {1'b0, i_num[31:1]};
            assign bit_i = i_num[0];
            assign den_i = i_den;
            assign quo_i = '0;
        end else begin : g_next
            assign rem_i = r_rem[k-1];
            assign bit_i = 1'b0;
            assign den_i = r_den[k-1];
            assign quo_i = r_quo[k-1];
        end

        assign acc = {rem_i, bit_i};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= den_i;
                if (acc >= {1'b0, den_i}) begin
                    r_rem[k] <= 32'(acc - {1'b0, den_i});
                    r_quo[k] <= {quo_i[FRAC_BITS-1:0], 1'b1};
                end else begin
                    r_rem[k] <= acc[31:0];
                    r_quo[k] <= {quo_i[FRAC_BITS-1:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[STAGES-1];

endmodule

@@ rtl/euler_flux_2d_unit.sv @@
// Latency: 46 + FRAC_BITS register stages (62 at Q16.16): 5 front, 32 square root,
//   FRAC_BITS+1 divide, 8 flux; output valid is registered in the last flux stage.
// Throughput: one item per cycle while the output is not stalled; every stage advances
//   together on a global enable that drops while the output is held and not taken.
// Reset: i_rst_n synchronous active low clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// euler_flux_2d_unit
// Compressible Euler fluxes of one cell's primitive state through a face whose
// normal has any length. Signed fixed point with FRAC_BITS fraction bits,
// saturated results and a status code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_flux_2d_unit_assert.svh"

module euler_flux_2d_unit #(
    parameter int FRAC_BITS = eflx_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // density[30:0], pressure[61:31], internal_energy[92:62], velocity_x[124:93],
    // velocity_y[156:125], normal_x[188:157], normal_y[220:189], zero fill
    input  logic [eflx_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // mass_flux[31:0], momentum_flux_x[63:32], momentum_flux_y[95:64],
    // energy_flux[127:96]
    output logic [eflx_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                         o_m_axis_tuser
);
    import eflx_pkg::*;

    localparam int UW  = FRAC_BITS + 2;      // signed unit normal component
    localparam int SW  = FRAC_BITS + 35;     // dot product v . u
    localparam int VW  = 35;                 // signed normal velocity
    localparam int PPW = 31 + UW;            // pressure times |u|
    localparam int PMW = 31 + VW;            // density times |vn|
    localparam int PEW = 32 + VW;            // (E + P) times |vn|
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int DLY = ISQRT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [30:0] rho;
        logic [30:0] pr;
        logic [30:0] e;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        neg_x;
        logic        neg_y;
        logic        zero;
        logic [31:0] an;
        logic [31:0] bn;
    } t_side;

    typedef struct packed {
        logic [30:0]    rho;
        logic [30:0]    pr;
        logic [30:0]    e;
        logic [31:0]    vx;
        logic [31:0]    vy;
        logic           zero;
        logic           sat;
        logic [UW-1:0]  ux;
        logic [UW-1:0]  uy;
        logic [63:0]    sqx;
        logic [63:0]    sqy;
        logic [63:0]    sq;
        logic [SW-1:0]  px;
        logic [SW-1:0]  py;
        logic [SW-1:0]  sdot;
        logic [31:0]    spec;
        logic [VW-1:0]  vn;
        logic [PPW-1:0] ppx;
        logic [PPW-1:0] ppy;
        logic [62:0]    pe;
        logic [PMW-1:0] pm;
        logic [30:0]    en;
        logic [32:0]    tpx;
        logic [32:0]    tpy;
        logic [31:0]    mf;
        logic [31:0]    enp;
        logic [63:0]    pmx;
        logic [63:0]    pmy;
        logic [PEW-1:0] pef;
        logic [31:0]    fx;
        logic [31:0]    fy;
        logic [31:0]    ef;
        t_status        status;
    } t_tail;

    // clamp a signed 68 bit value to 32 bits; bit 32 of the result flags a clamp
    function automatic logic [32:0] sat32(input logic [67:0] x);
        logic [32:0] res;
        if (x[67:31] == '0 || x[67:31] == '1) begin
            res = {1'b0, x[31:0]};
        end else if (x[67]) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        return res;
    endfunction

    function automatic logic [67:0] apply_sign(input logic neg, input logic [67:0] m);
        return neg ? (~m + 68'd1) : m;
    endfunction

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output register is free
    // or being drained. Valid bits travel with the data.
    // ------------------------------------------------------------------
    logic en;

    logic  r_va, r_vb, r_vc, r_vd, r_ve;
    logic  r_dv [DLY];
    logic  r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;

    t_side r_sa, r_sb, r_sc, r_sd, r_se;
    t_side n_sa;
    t_side n_sc;
    logic [4:0]  r_shb, n_shb;
    logic [63:0] r_aa, r_bb, r_rad;
    t_side r_dly [DLY];

    logic [31:0]          w_root;
    logic [FRAC_BITS:0]   w_qx, w_qy;

    t_tail r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_t8;
    t_tail n_t1, n_t2, n_t3, n_t4, n_t5, n_t6, n_t7, n_t8;

    assign en              = !r_v8 || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            for (int i = 0; i < DLY; i++) begin
                r_dv[i] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (en) begin
            r_va    <= i_s_axis_tvalid;
            r_vb    <= r_va;
            r_vc    <= r_vb;
            r_vd    <= r_vc;
            r_ve    <= r_vd;
            r_dv[0] <= r_ve;
            for (int i = 1; i < DLY; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_v1 <= r_dv[DLY-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // ------------------------------------------------------------------
    // Front: unpack, take normal magnitudes, find and apply the shift that
    // brings the larger magnitude to 2^30 or above, square and sum.
    // ------------------------------------------------------------------
    always_comb begin
        logic [31:0] nx;
        logic [31:0] ny;
        nx          = i_s_axis_tdata[188:157];
        ny          = i_s_axis_tdata[220:189];
        n_sa.rho    = i_s_axis_tdata[30:0];
        n_sa.pr     = i_s_axis_tdata[61:31];
        n_sa.e      = i_s_axis_tdata[92:62];
        n_sa.vx     = i_s_axis_tdata[124:93];
        n_sa.vy     = i_s_axis_tdata[156:125];
        n_sa.neg_x  = nx[31];
        n_sa.neg_y  = ny[31];
        n_sa.zero   = (nx == '0) && (ny == '0);
        n_sa.an     = nx[31] ? (~nx + 32'd1) : nx;
        n_sa.bn     = ny[31] ? (~ny + 32'd1) : ny;
    end

    // shift amount: 30 minus the position of the leading one, none if bit 30
    // or 31 is already set
    always_comb begin
        logic [31:0] orv;
        orv   = r_sa.an | r_sa.bn;
        n_shb = '0;
        for (int i = 0; i < 30; i++) begin
            if (orv[i]) begin
                n_shb = 5'(30 - i);
            end
        end
        if (orv[31] || orv[30]) begin
            n_shb = '0;
        end
    end

    // apply the common shift to both magnitudes
    always_comb begin
        n_sc    = r_sb;
        n_sc.an = r_sb.an << r_shb;
        n_sc.bn = r_sb.bn << r_shb;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa  <= n_sa;
            r_sb  <= r_sa;
            r_shb <= n_shb;
            r_sc  <= n_sc;
            r_sd  <= r_sc;
            r_aa  <= 64'(r_sc.an) * 64'(r_sc.an);
            r_bb  <= 64'(r_sc.bn) * 64'(r_sc.bn);
            r_se  <= r_sd;
            r_rad <= r_aa + r_bb;
            r_dly[0] <= r_se;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Length of the normal, then both unit components in parallel dividers.
    // ------------------------------------------------------------------
    eflx_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    eflx_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_dly[ISQRT_STAGES-1].an),
        .i_den (w_root),
        .o_quo (w_qx)
    );

    eflx_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_dly[ISQRT_STAGES-1].bn),
        .i_den (w_root),
        .o_quo (w_qy)
    );

    // ------------------------------------------------------------------
    // Flux stages
    // ------------------------------------------------------------------
    // T1: signed unit normal, squared speed parts
    always_comb begin
        logic [31:0] vxm;
        logic [31:0] vym;
        n_t1      = '0;
        n_t1.rho  = r_dly[DLY-1].rho;
        n_t1.pr   = r_dly[DLY-1].pr;
        n_t1.e    = r_dly[DLY-1].e;
        n_t1.vx   = r_dly[DLY-1].vx;
        n_t1.vy   = r_dly[DLY-1].vy;
        n_t1.zero = r_dly[DLY-1].zero;
        n_t1.ux   = r_dly[DLY-1].neg_x ? (~{1'b0, w_qx} + 1'b1) : {1'b0, w_qx};
        n_t1.uy   = r_dly[DLY-1].neg_y ? (~{1'b0, w_qy} + 1'b1) : {1'b0, w_qy};
        vxm       = r_dly[DLY-1].vx[31] ? (~r_dly[DLY-1].vx + 32'd1) : r_dly[DLY-1].vx;
        vym       = r_dly[DLY-1].vy[31] ? (~r_dly[DLY-1].vy + 32'd1) : r_dly[DLY-1].vy;
        n_t1.sqx  = 64'(vxm) * 64'(vxm);
        n_t1.sqy  = 64'(vym) * 64'(vym);
    end

    // T2: velocity times unit normal, squared speed sum
    always_comb begin
        n_t2    = r_t1;
        n_t2.px = $signed(r_t1.vx) * $signed(r_t1.ux);
        n_t2.py = $signed(r_t1.vy) * $signed(r_t1.uy);
        n_t2.sq = r_t1.sqx + r_t1.sqy;
    end

    // T3: dot product, specific total energy with clamp to 32 bits
    always_comb begin
        logic [63:0] sp;
        n_t3      = r_t2;
        n_t3.sdot = $signed(r_t2.px) + $signed(r_t2.py);
        sp        = (r_t2.sq >> (FRAC_BITS + 1)) + 64'(r_t2.e);
        if (sp > 64'h0000_0000_FFFF_FFFF) begin
            n_t3.spec = '1;
            n_t3.sat  = 1'b1;
        end else begin
            n_t3.spec = sp[31:0];
        end
    end

    // T4: normal velocity rounded toward zero, pressure and energy products
    always_comb begin
        logic          sneg;
        logic [SW-1:0] smag;
        logic [VW-1:0] vmag;
        logic [UW-1:0] uxm;
        logic [UW-1:0] uym;
        n_t4    = r_t3;
        sneg    = r_t3.sdot[SW-1];
        smag    = sneg ? (~r_t3.sdot + 1'b1) : r_t3.sdot;
        vmag    = VW'(smag >> FRAC_BITS);
        n_t4.vn = sneg ? (~vmag + 1'b1) : vmag;
        uxm     = r_t3.ux[UW-1] ? (~r_t3.ux + 1'b1) : r_t3.ux;
        uym     = r_t3.uy[UW-1] ? (~r_t3.uy + 1'b1) : r_t3.uy;
        n_t4.ppx = PPW'(r_t3.pr) * PPW'(uxm);
        n_t4.ppy = PPW'(r_t3.pr) * PPW'(uym);
        n_t4.pe  = 63'(r_t3.rho) * 63'(r_t3.spec);
    end

    // T5: mass product, clamp total energy, pressure terms signed
    always_comb begin
        logic [VW-1:0]  vnm;
        logic [62:0]    pes;
        logic [PPW-1:0] tqx;
        logic [PPW-1:0] tqy;
        n_t5    = r_t4;
        vnm     = r_t4.vn[VW-1] ? (~r_t4.vn + 1'b1) : r_t4.vn;
        n_t5.pm = PMW'(r_t4.rho) * PMW'(vnm);
        pes     = r_t4.pe >> FRAC_BITS;
        if (pes > 63'h7FFF_FFFF) begin
            n_t5.en  = '1;
            n_t5.sat = 1'b1;
        end else begin
            n_t5.en = pes[30:0];
        end
        tqx      = r_t4.ppx >> FRAC_BITS;
        tqy      = r_t4.ppy >> FRAC_BITS;
        n_t5.tpx = r_t4.ux[UW-1] ? (~33'(tqx) + 33'd1) : 33'(tqx);
        n_t5.tpy = r_t4.uy[UW-1] ? (~33'(tqy) + 33'd1) : 33'(tqy);
    end

    // T6: saturate mass flux, energy plus pressure
    always_comb begin
        logic [32:0] ms;
        n_t6     = r_t5;
        ms       = sat32(apply_sign(r_t5.vn[VW-1], 68'(r_t5.pm >> FRAC_BITS)));
        n_t6.mf  = ms[31:0];
        n_t6.sat = r_t5.sat | ms[32];
        n_t6.enp = 32'(r_t5.en) + 32'(r_t5.pr);
    end

    // T7: convective momentum products and energy product
    always_comb begin
        logic [31:0]   mfm;
        logic [31:0]   vxm;
        logic [31:0]   vym;
        logic [VW-1:0] vnm;
        n_t7     = r_t6;
        mfm      = r_t6.mf[31] ? (~r_t6.mf + 32'd1) : r_t6.mf;
        vxm      = r_t6.vx[31] ? (~r_t6.vx + 32'd1) : r_t6.vx;
        vym      = r_t6.vy[31] ? (~r_t6.vy + 32'd1) : r_t6.vy;
        vnm      = r_t6.vn[VW-1] ? (~r_t6.vn + 1'b1) : r_t6.vn;
        n_t7.pmx = 64'(mfm) * 64'(vxm);
        n_t7.pmy = 64'(mfm) * 64'(vym);
        n_t7.pef = PEW'(r_t6.enp) * PEW'(vnm);
    end

    // T8: sum and saturate momentum and energy fluxes, form status
    always_comb begin
        logic [67:0] sx;
        logic [67:0] sy;
        logic [32:0] fxs;
        logic [32:0] fys;
        logic [32:0] efs;
        n_t8 = r_t7;
        sx   = {{35{r_t7.tpx[32]}}, r_t7.tpx}
             + apply_sign(r_t7.mf[31] ^ r_t7.vx[31], 68'(r_t7.pmx >> FRAC_BITS));
        sy   = {{35{r_t7.tpy[32]}}, r_t7.tpy}
             + apply_sign(r_t7.mf[31] ^ r_t7.vy[31], 68'(r_t7.pmy >> FRAC_BITS));
        fxs  = sat32(sx);
        fys  = sat32(sy);
        efs  = sat32(apply_sign(r_t7.vn[VW-1], 68'(r_t7.pef >> FRAC_BITS)));
        if (r_t7.zero) begin
            // zero normal: drop all fluxes
            n_t8.mf     = '0;
            n_t8.fx     = '0;
            n_t8.fy     = '0;
            n_t8.ef     = '0;
            n_t8.status = ST_ZERO;
        end else begin
            n_t8.fx     = fxs[31:0];
            n_t8.fy     = fys[31:0];
            n_t8.ef     = efs[31:0];
            n_t8.status = (r_t7.sat || fxs[32] || fys[32] || efs[32]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_t4 <= n_t4;
            r_t5 <= n_t5;
            r_t6 <= n_t6;
            r_t7 <= n_t7;
            r_t8 <= n_t8;
        end
    end

    // Output register: hold until taken
    assign o_m_axis_tvalid = r_v8;
    assign o_m_axis_tdata  = {r_t8.ef, r_t8.fy, r_t8.fx, r_t8.mf};
    assign o_m_axis_tuser  = r_t8.status;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `EFLX_ASSERT_NOW(a_zero_clears, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser == ST_ZERO, o_m_axis_tdata == '0)
    `EFLX_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_ZERO || o_m_axis_tuser == ST_SAT)
    `EFLX_ASSERT_NOW(a_ready_full, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid)
    `EFLX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tuser))

endmodule
